### hdl/sabpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabpi_pkg
// Shared types and constants of the split accelerator/brake PI speed
// controller.
// ----------------------------------------------------------------------------
package sabpi_pkg;

    localparam int FRAC_BITS = 8;

    localparam logic [14:0] LOW_TARGET_LIMIT  = 15'd434;
    localparam logic [14:0] LOW_CURRENT_LIMIT = 15'd142;

    localparam int          BLEED_VALUE  = ((9 << FRAC_BITS) + 5) / 10;
    localparam logic [14:0] BLEED_AMOUNT = 15'(BLEED_VALUE);

    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;

    localparam logic [2:0] CFG_ACCEL_P_GAIN = 3'd0;
    localparam logic [2:0] CFG_ACCEL_I_GAIN = 3'd1;
    localparam logic [2:0] CFG_BRAKE_P_GAIN = 3'd2;
    localparam logic [2:0] CFG_BRAKE_I_GAIN = 3'd3;
    localparam logic [2:0] CFG_ACCEL_UPPER  = 3'd4;
    localparam logic [2:0] CFG_ACCEL_LOWER  = 3'd5;
    localparam logic [2:0] CFG_BRAKE_UPPER  = 3'd6;
    localparam logic [2:0] CFG_BRAKE_LOWER  = 3'd7;

    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_ACCEL = 2'd1,
        MODE_BRAKE = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [GAIN_W-1:0] accel_p_gain;
        logic signed [GAIN_W-1:0] accel_i_gain;
        logic signed [GAIN_W-1:0] brake_p_gain;
        logic signed [GAIN_W-1:0] brake_i_gain;
        logic [LIMIT_W-1:0]       accel_upper;
        logic [LIMIT_W-1:0]       accel_lower;
        logic [LIMIT_W-1:0]       brake_upper;
        logic [LIMIT_W-1:0]       brake_lower;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic signed [16:0] err;
        logic signed [32:0] p_prod;
        logic signed [34:0] i_prod;
    } t_stage;

endpackage

### hdl/split_accel_brake_pi_speed_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_accel_brake_pi_speed_controller
// PI speed controller driving separate accelerator and brake pedal commands.
//
// Slave stream: tdata carries target speed and measured speed, signed Q8.8.
// Master stream: tdata carries accel and brake commands (unsigned Q7.8
// percent), the speed error and the control mode.
// Configuration: write enable, register index and data; gains and limits
// are to be written while the stream is idle; the block does not enforce it.
//
// Pipeline: two register stages, the input stage register and the output
// result register; a result can wait in either while the receiver stalls.
// Throughput: one transaction per cycle while the receiver accepts; the
// integral add-and-clamp loop around the output stage registers is combinational.
// The input stage keeps accepting while a result waits, as long as its own
// register is free; a stalled receiver then back-pressures the slave side.
// Reset clears both integrals, empties the pipeline and restores the
// default gains and limits.
// ----------------------------------------------------------------------------
module split_accel_brake_pi_speed_controller import sabpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: target_velocity[15:0], current_velocity[31:16]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    // tdata: accel_command[14:0], brake_command[29:15], velocity_error[46:30],
    //        control_mode[48:47], zero fill[55:49]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg   w_cfg;
    t_stage w_stage;
    logic   w_stage_valid;
    logic   w_stage_ready;

    sabpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    sabpi_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_stage_valid),
        .i_ready (w_stage_ready),
        .o_stage (w_stage)
    );

    sabpi_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_stage_valid),
        .o_ready (w_stage_ready),
        .i_stage (w_stage),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

### hdl/sabpi_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabpi_cfg
// Gain and limit register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sabpi_cfg import sabpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_p_gain <= 16'sd998;
            r_cfg.accel_i_gain <= 16'sd26;
            r_cfg.brake_p_gain <= -16'sd2304;
            r_cfg.brake_i_gain <= -16'sd128;
            r_cfg.accel_upper  <= 15'd6400;
            r_cfg.accel_lower  <= 15'd1280;
            r_cfg.brake_upper  <= 15'd8960;
            r_cfg.brake_lower  <= 15'd1280;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACCEL_P_GAIN: r_cfg.accel_p_gain <= $signed(i_cfg_wdata);
                CFG_ACCEL_I_GAIN: r_cfg.accel_i_gain <= $signed(i_cfg_wdata);
                CFG_BRAKE_P_GAIN: r_cfg.brake_p_gain <= $signed(i_cfg_wdata);
                CFG_BRAKE_I_GAIN: r_cfg.brake_i_gain <= $signed(i_cfg_wdata);
                CFG_ACCEL_UPPER:  r_cfg.accel_upper  <= i_cfg_wdata[14:0];
                CFG_ACCEL_LOWER:  r_cfg.accel_lower  <= i_cfg_wdata[14:0];
                CFG_BRAKE_UPPER:  r_cfg.brake_upper  <= i_cfg_wdata[14:0];
                CFG_BRAKE_LOWER:  r_cfg.brake_lower  <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/sabpi_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabpi_mult
// Input stage: speed error, mode decode and the two gain products.
// ----------------------------------------------------------------------------
module sabpi_mult import sabpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_stage      o_stage
);

    logic signed [15:0] w_tv;
    logic signed [15:0] w_cv;
    logic signed [16:0] w_err;
    logic               w_low;
    t_mode              w_mode;
    logic signed [15:0] w_p_gain;
    logic signed [17:0] w_i_gain;
    logic signed [32:0] w_p_prod;
    logic signed [34:0] w_i_prod;

    logic   r_valid;
    t_stage r_stage;

    assign w_tv  = $signed(i_data[15:0]);
    assign w_cv  = $signed(i_data[31:16]);
    assign w_err = $signed({w_tv[15], w_tv}) - $signed({w_cv[15], w_cv});

    assign w_low = (!w_tv[15] && (w_tv[14:0] <= LOW_TARGET_LIMIT)) ||
                   (!w_cv[15] && (w_cv[14:0] <= LOW_CURRENT_LIMIT));

    always_comb begin
        if (w_low) begin
            w_mode = MODE_LOW;
        end else if (!w_err[16] && (|w_err[15:0])) begin
            w_mode = MODE_ACCEL;
        end else begin
            w_mode = MODE_BRAKE;
        end
    end

    always_comb begin
        case (w_mode)
            MODE_ACCEL: begin
                w_p_gain = i_cfg.accel_p_gain;
                w_i_gain = $signed({{2{i_cfg.accel_i_gain[15]}}, i_cfg.accel_i_gain});
            end
            MODE_BRAKE: begin
                w_p_gain = i_cfg.brake_p_gain;
                // scale the brake integral gain by three, halved later in rounding
                w_i_gain = $signed({i_cfg.brake_i_gain[15], i_cfg.brake_i_gain, 1'b0}) +
                           $signed({{2{i_cfg.brake_i_gain[15]}}, i_cfg.brake_i_gain});
            end
            default: begin
                w_p_gain = i_cfg.brake_p_gain;
                w_i_gain = $signed({{2{i_cfg.brake_i_gain[15]}}, i_cfg.brake_i_gain});
            end
        endcase
    end

    assign w_p_prod = $signed({{17{w_p_gain[15]}}, w_p_gain}) *
                      $signed({{16{w_err[16]}}, w_err});
    assign w_i_prod = $signed({{17{w_i_gain[17]}}, w_i_gain}) *
                      $signed({{18{w_err[16]}}, w_err});

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stage.mode   <= w_mode;
            r_stage.err    <= w_err;
            r_stage.p_prod <= w_p_prod;
            r_stage.i_prod <= w_i_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### hdl/sabpi_integ.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabpi_integ
// Output stage: rounding, PI sum, integral update with anti-windup and
// command clamping into the result register.
// ----------------------------------------------------------------------------
module sabpi_integ import sabpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_stage      i_stage,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [55:0] o_data
);

    function automatic logic signed [16:0] round_sat(input logic signed [34:0] v,
                                                     input logic extra);
        logic signed [35:0] sum;
        logic signed [35:0] shifted;
        logic signed [16:0] res;
        sum = $signed({v[34], v}) +
              (extra ? (36'sd1 <<< FRAC_BITS) : (36'sd1 <<< (FRAC_BITS - 1)));
        shifted = extra ? (sum >>> (FRAC_BITS + 1)) : (sum >>> FRAC_BITS);
        if (shifted > 36'sd65535) begin
            res = 17'sd65535;
        end else if (shifted < -36'sd65536) begin
            res = -17'sd65536;
        end else begin
            res = shifted[16:0];
        end
        return res;
    endfunction

    logic               w_ld;
    logic               w_accel;
    logic signed [16:0] w_p;
    logic signed [16:0] w_i;
    logic [14:0]        w_int;
    logic [14:0]        w_lo;
    logic [14:0]        w_up;
    logic signed [18:0] w_inew;
    logic signed [19:0] w_cmd;
    logic [14:0]        w_cmd_clamp;
    logic [14:0]        w_int_clamp;
    logic [14:0]        w_bleed;

    logic               r_o_valid;
    logic [14:0]        r_accel_int;
    logic [14:0]        r_brake_int;
    logic [14:0]        r_accel_cmd;
    logic [14:0]        r_brake_cmd;
    logic signed [16:0] r_err;
    t_mode              r_mode;

    assign o_ready = !r_o_valid || i_ready;
    assign w_ld    = i_valid && o_ready;
    assign w_accel = (i_stage.mode == MODE_ACCEL);

    assign w_p = round_sat($signed({{2{i_stage.p_prod[32]}}, i_stage.p_prod}), 1'b0);
    assign w_i = round_sat(i_stage.i_prod, i_stage.mode == MODE_BRAKE);

    assign w_int = w_accel ? r_accel_int : r_brake_int;
    assign w_lo  = w_accel ? i_cfg.accel_lower : i_cfg.brake_lower;
    assign w_up  = w_accel ? i_cfg.accel_upper : i_cfg.brake_upper;

    assign w_inew = $signed({4'b0, w_int}) + $signed({{2{w_i[16]}}, w_i});
    assign w_cmd  = $signed({5'b0, w_lo}) + $signed({{3{w_p[16]}}, w_p}) +
                    $signed({w_inew[18], w_inew});

    always_comb begin
        if (w_inew <= 19'sd0) begin
            w_int_clamp = 15'd0;
        end else if (w_inew >= $signed({4'b0, w_up})) begin
            w_int_clamp = w_up;
        end else begin
            w_int_clamp = w_inew[14:0];
        end
    end

    always_comb begin
        if (w_accel) begin
            if (w_cmd >= $signed({5'b0, w_up})) begin
                w_cmd_clamp = w_up;
            end else if (w_cmd <= $signed({5'b0, w_lo})) begin
                w_cmd_clamp = w_lo;
            end else begin
                w_cmd_clamp = w_cmd[14:0];
            end
        end else begin
            if (w_cmd <= $signed({5'b0, w_lo})) begin
                w_cmd_clamp = w_lo;
            end else if (w_cmd >= $signed({5'b0, w_up})) begin
                w_cmd_clamp = w_up;
            end else begin
                w_cmd_clamp = w_cmd[14:0];
            end
        end
    end

    assign w_bleed = (r_brake_int < BLEED_AMOUNT) ? 15'd0 : (r_brake_int - BLEED_AMOUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid   <= 1'b0;
            r_accel_int <= 15'd0;
            r_brake_int <= 15'd0;
        end else begin
            if (o_ready) begin
                r_o_valid <= i_valid;
            end
            if (w_ld) begin
                case (i_stage.mode)
                    MODE_ACCEL: begin
                        r_accel_int <= w_int_clamp;
                        r_brake_int <= w_bleed;
                    end
                    MODE_BRAKE: begin
                        r_brake_int <= w_int_clamp;
                        r_accel_int <= 15'd0;
                    end
                    default: begin
                        r_brake_int <= w_int_clamp;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_err  <= i_stage.err;
            r_mode <= i_stage.mode;
            case (i_stage.mode)
                MODE_ACCEL: begin
                    r_accel_cmd <= w_cmd_clamp;
                    r_brake_cmd <= 15'd0;
                end
                MODE_BRAKE: begin
                    r_accel_cmd <= i_cfg.accel_lower;
                    r_brake_cmd <= w_cmd_clamp;
                end
                default: begin
                    r_accel_cmd <= 15'd0;
                    r_brake_cmd <= w_cmd_clamp;
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = {7'b0, r_mode, r_err, r_brake_cmd, r_accel_cmd};

    a_accel_no_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_mode == MODE_ACCEL) |-> (r_brake_cmd == 15'd0))
        else $error("brake command active in accelerate mode");

    a_low_no_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_mode == MODE_LOW) |-> (r_accel_cmd == 15'd0))
        else $error("accel command active in low-speed mode");

    a_bleed_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld && w_accel) |=> (r_brake_int <= $past(r_brake_int)))
        else $error("brake integral grew in accelerate mode");

    a_brake_clears_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld && i_stage.mode == MODE_BRAKE) |=> (r_accel_int == 15'd0))
        else $error("accel integral not cleared in brake mode");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the split accelerator/brake PI speed controller.
// A scoreboard predicts pedal commands, speed error and mode for every
// accepted speed transaction. Runs go through short directed parts, then
// extreme and random gain/limit settings with runs of accelerate, brake, low-speed and
// noise traffic. Random gaps fall on both stream sides, and one long
// receiver hold-off back-pressures the input.
// ----------------------------------------------------------------------------
module testbench;
    import sabpi_pkg::*;

    typedef struct {
        logic [14:0]        accel;
        logic [14:0]        brake;
        logic signed [16:0] err;
        t_mode              mode;
    } t_pedal_result;

    class t_pedal_scoreboard;
        logic signed [15:0] accel_p, accel_i, brake_p, brake_i;
        logic [14:0]        accel_up, accel_lo, brake_up, brake_lo;
        longint             brake_integral, accel_integral;
        t_pedal_result      queued_commands[$];
        int                 errors;

        function new();
            accel_p = 16'sd998;
            accel_i = 16'sd26;
            brake_p = -16'sd2304;
            brake_i = -16'sd128;
            accel_up = 15'd6400;
            accel_lo = 15'd1280;
            brake_up = 15'd8960;
            brake_lo = 15'd1280;
            brake_integral = 0;
            accel_integral = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                CFG_ACCEL_P_GAIN: accel_p = v;
                CFG_ACCEL_I_GAIN: accel_i = v;
                CFG_BRAKE_P_GAIN: brake_p = v;
                CFG_BRAKE_I_GAIN: brake_i = v;
                CFG_ACCEL_UPPER:  accel_up = v[14:0];
                CFG_ACCEL_LOWER:  accel_lo = v[14:0];
                CFG_BRAKE_UPPER:  brake_up = v[14:0];
                default:          brake_lo = v[14:0];
            endcase
        endfunction

        // round to nearest, ties up, then saturate to 17 bits signed
        function longint scaled_product(longint v, int s);
            longint r;
            r = (v + (longint'(1) <<< (s - 1))) >>> s;
            if (r > 65535) r = 65535;
            if (r < -65536) r = -65536;
            return r;
        endfunction

        function longint clamp_integral(longint i, longint upper);
            if (i <= 0) return 0;
            if (i >= upper) return upper;
            return i;
        endfunction

        function void note_speeds(logic [31:0] d);
            longint        tv, cv, err, p, inew, cmd, a_up, a_lo, b_up, b_lo;
            t_pedal_result r;
            tv = longint'($signed(d[15:0]));
            cv = longint'($signed(d[31:16]));
            err = tv - cv;
            a_up = longint'(accel_up);
            a_lo = longint'(accel_lo);
            b_up = longint'(brake_up);
            b_lo = longint'(brake_lo);
            if ((tv >= 0 && tv <= longint'(LOW_TARGET_LIMIT)) ||
                (cv >= 0 && cv <= longint'(LOW_CURRENT_LIMIT)))
                r.mode = MODE_LOW;
            else if (err > 0)
                r.mode = MODE_ACCEL;
            else
                r.mode = MODE_BRAKE;

            if (r.mode == MODE_ACCEL) begin
                p = scaled_product(longint'(accel_p) * err, FRAC_BITS);
                inew = accel_integral + scaled_product(longint'(accel_i) * err, FRAC_BITS);
                cmd = a_lo + p + inew;
                accel_integral = clamp_integral(inew, a_up);
                if (cmd >= a_up) cmd = a_up;
                else if (cmd <= a_lo) cmd = a_lo;
                r.accel = 15'(cmd);
                r.brake = '0;
                brake_integral = brake_integral - BLEED_VALUE;
                if (brake_integral < 0) brake_integral = 0;
            end else begin
                p = scaled_product(longint'(brake_p) * err, FRAC_BITS);
                if (r.mode == MODE_LOW)
                    inew = brake_integral +
                           scaled_product(longint'(brake_i) * err, FRAC_BITS);
                else
                    inew = brake_integral +
                           scaled_product(longint'(brake_i) * err * 3, FRAC_BITS + 1);
                cmd = b_lo + p + inew;
                brake_integral = clamp_integral(inew, b_up);
                if (cmd <= b_lo) cmd = b_lo;
                else if (cmd >= b_up) cmd = b_up;
                r.brake = 15'(cmd);
                if (r.mode == MODE_LOW) begin
                    r.accel = '0;
                end else begin
                    r.accel = accel_lo;
                    accel_integral = 0;
                end
            end
            r.err = 17'(err);
            queued_commands.insert(queued_commands.size(), r);
        endfunction

        function void check_commands(logic [55:0] d);
            t_pedal_result e;
            if (queued_commands.size() == 0) begin
                $error("unexpected result transaction: tdata %h", d);
                errors++;
                return;
            end
            e = queued_commands.pop_front();
            if (d[14:0] !== e.accel) begin
                $error("accel_command: expected %0d, actual %0d", e.accel, d[14:0]);
                errors++;
            end
            if (d[29:15] !== e.brake) begin
                $error("brake_command: expected %0d, actual %0d", e.brake, d[29:15]);
                errors++;
            end
            if (d[46:30] !== e.err) begin
                $error("velocity_error: expected %0d, actual %0d",
                       e.err, $signed(d[46:30]));
                errors++;
            end
            if (d[48:47] !== e.mode) begin
                $error("control_mode: expected %0d, actual %0d", e.mode, d[48:47]);
                errors++;
            end
        endfunction

        function int pending();
            return queued_commands.size();
        endfunction
    endclass

    localparam int CORNER_SPEEDS[9] = '{-32768, -1, 0, 1, 32767, 434, 435, 142, 143};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // tdata: target_velocity[15:0], current_velocity[31:16]
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // tdata: accel_command[14:0], brake_command[29:15], velocity_error[46:30],
    //        control_mode[48:47]
    logic [55:0] o_m_axis_tdata;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    t_pedal_scoreboard pedal_sb = new();
    logic [15:0]       cfg_image[8];
    bit                src_idle;
    int                phase_items;

    always #1 i_clk = ~i_clk;

    split_accel_brake_pi_speed_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    task automatic drive_speeds(input int tv, input int cv);
        logic [31:0] d;
        int          gap;
        d = {cv[15:0], tv[15:0]};
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pedal_sb.note_speeds(d);
        phase_items++;
    endtask

    // drop valid and drain all outstanding results
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pedal_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config();
        logic [2:0] idx;
        for (int i = 0; i < 8; i++) begin
            idx = 3'(i);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= cfg_image[i];
            pedal_sb.write_reg(idx, cfg_image[i]);
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [15:0] random_limit();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd25600;
            2:       return 16'h7fff;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 25600));
        endcase
    endfunction

    task automatic random_config(input int phase);
        logic [15:0] hi, lo;
        if (phase == 0) begin
            cfg_image[CFG_ACCEL_P_GAIN] = 16'h7fff;
            cfg_image[CFG_ACCEL_I_GAIN] = 16'h7fff;
            cfg_image[CFG_BRAKE_P_GAIN] = 16'h7fff;
            cfg_image[CFG_BRAKE_I_GAIN] = 16'h7fff;
            cfg_image[CFG_ACCEL_UPPER]  = 16'd25600;
            cfg_image[CFG_ACCEL_LOWER]  = 16'd0;
            cfg_image[CFG_BRAKE_UPPER]  = 16'd25600;
            cfg_image[CFG_BRAKE_LOWER]  = 16'd0;
        end else if (phase == 1) begin
            cfg_image[CFG_ACCEL_P_GAIN] = 16'h8000;
            cfg_image[CFG_ACCEL_I_GAIN] = 16'h8000;
            cfg_image[CFG_BRAKE_P_GAIN] = 16'h8000;
            cfg_image[CFG_BRAKE_I_GAIN] = 16'h8000;
            cfg_image[CFG_ACCEL_UPPER]  = 16'h7fff;
            cfg_image[CFG_ACCEL_LOWER]  = 16'd25600;
            cfg_image[CFG_BRAKE_UPPER]  = 16'h7fff;
            cfg_image[CFG_BRAKE_LOWER]  = 16'd0;
        end else begin
            cfg_image[CFG_ACCEL_P_GAIN] = random_gain();
            cfg_image[CFG_ACCEL_I_GAIN] = random_gain();
            cfg_image[CFG_BRAKE_P_GAIN] = random_gain();
            cfg_image[CFG_BRAKE_I_GAIN] = random_gain();
            hi = random_limit();
            lo = random_limit();
            if (hi[14:0] < lo[14:0] && $urandom_range(0, 4) != 0) {hi, lo} = {lo, hi};
            cfg_image[CFG_ACCEL_UPPER] = hi;
            cfg_image[CFG_ACCEL_LOWER] = lo;
            hi = random_limit();
            lo = random_limit();
            if (hi[14:0] < lo[14:0] && $urandom_range(0, 4) != 0) {hi, lo} = {lo, hi};
            cfg_image[CFG_BRAKE_UPPER] = hi;
            cfg_image[CFG_BRAKE_LOWER] = lo;
        end
        load_config();
    endtask

    task automatic drive_run();
        int kind, len, base, tv, cv;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(4, 24);
        base = $urandom_range(200, 20000);
        src_idle = ($urandom_range(0, 3) != 0);
        repeat (len) begin
            base = base + int'($urandom_range(0, 400)) - 200;
            cv = base;
            case (kind)
                0: begin
                    tv = $urandom;
                    cv = $urandom;
                end
                1: begin
                    tv = CORNER_SPEEDS[$urandom_range(0, 8)];
                    cv = CORNER_SPEEDS[$urandom_range(0, 8)];
                end
                2, 3: begin
                    tv = int'($urandom_range(0, 700)) - 100;
                    if ($urandom_range(0, 1) == 1) begin
                        tv = base;
                        cv = int'($urandom_range(0, 250)) - 50;
                    end
                end
                4, 5, 6: tv = base + int'($urandom_range(1, 3000));
                7, 8:    tv = base - int'($urandom_range(0, 3000));
                default: tv = base + int'($urandom_range(0, 4000)) - 2000;
            endcase
            drive_speeds(tv, cv);
        end
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : result_sink
        int gap, seen;
        bit sink_idle;
        seen = 0;
        sink_idle = 1'b1;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (seen % 64 == 0) sink_idle = ($urandom_range(0, 3) != 0);
            gap = sink_idle ? $urandom_range(0, 11) : 0;
            if (seen == 300) gap = 160;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            pedal_sb.check_commands(o_m_axis_tdata);
            seen++;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        src_idle = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: mode boundaries, saturation, integral build-up and bleed
        drive_speeds(0, 0);
        drive_speeds(434, 1000);
        drive_speeds(435, 1000);
        drive_speeds(1000, 142);
        drive_speeds(1000, 143);
        drive_speeds(-1, 1000);
        drive_speeds(1000, -1);
        drive_speeds(32767, -32768);
        drive_speeds(-32768, 32767);
        drive_speeds(5000, 5000);
        drive_speeds(32767, 32767);
        drive_speeds(-32768, -32768);
        repeat (4) drive_speeds(3000, 1000);
        repeat (4) drive_speeds(1000, 3000);
        repeat (2) drive_speeds(3000, 1000);
        settle();

        // unit gains for rounding ties, floors above ceilings
        cfg_image[CFG_ACCEL_P_GAIN] = 16'd1;
        cfg_image[CFG_ACCEL_I_GAIN] = 16'd1;
        cfg_image[CFG_BRAKE_P_GAIN] = 16'hffff;
        cfg_image[CFG_BRAKE_I_GAIN] = 16'd1;
        cfg_image[CFG_ACCEL_UPPER]  = 16'd100;
        cfg_image[CFG_ACCEL_LOWER]  = 16'd25600;
        cfg_image[CFG_BRAKE_UPPER]  = 16'd0;
        cfg_image[CFG_BRAKE_LOWER]  = 16'h7fff;
        load_config();
        drive_speeds(1128, 1000);
        drive_speeds(1000, 1128);
        drive_speeds(200, 328);
        drive_speeds(3000, 1000);
        drive_speeds(1000, 3000);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            random_config(phase);
            phase_items = 0;
            while (phase_items < 100) drive_run();
            settle();
        end

        while (pedal_sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pedal_sb.pending() != 0) begin
            $error("%0d expected results never arrived", pedal_sb.pending());
            pedal_sb.errors++;
        end
        if (pedal_sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
